### rtl/assert_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock out of reset.
`define HSV_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("hsv2rgb check failed");

// Consequent must hold in the same cycle as the antecedent.
`define HSV_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hsv2rgb check failed");

// Consequent must hold in the cycle after the antecedent.
`define HSV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hsv2rgb check failed");

`endif

### rtl/hsv2rgb_pkg.sv
// Shared types, constants and fixed-point helpers for the HSV to RGB565 converter.
package hsv2rgb_pkg;

    localparam int IN_W       = 16;
    localparam int FULL_SCALE = (1 << IN_W) - 1;
    localparam int FRAC_BITS  = 16;
    localparam int HUE_CIRCLE = 360;
    localparam int SECTOR_DEG = 60;
    localparam int RB_MAX     = 31;
    localparam int G_MAX      = 63;
    localparam int RB_W       = 5;
    localparam int G_W        = 6;
    localparam int PROD_W     = 2 * IN_W;

    // Hue / 360 by reciprocal: estimate is exact or one low.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_360   = (1 << RECIP_SHIFT) / HUE_CIRCLE;
    localparam int QE_W        = $clog2(FULL_SCALE / HUE_CIRCLE + 1);
    localparam int H_W         = $clog2(HUE_CIRCLE);
    localparam int REM_W       = $clog2(SECTOR_DEG);

    typedef enum logic [2:0] {
        SEC_RED_YEL,
        SEC_YEL_GRN,
        SEC_GRN_CYN,
        SEC_CYN_BLU,
        SEC_BLU_MAG,
        SEC_MAG_RED
    } t_sector;

    typedef logic [SECTOR_DEG-1:0][FRAC_BITS-1:0] t_frac_tab;

    // Sector fraction floor(rem * 2^FRAC_BITS / 60), built at elaboration.
    function automatic t_frac_tab f_frac_tab();
        t_frac_tab tab;
        longint    num;
        for (int i = 0; i < SECTOR_DEG; i++) begin
            num    = longint'(i) << FRAC_BITS;
            tab[i] = FRAC_BITS'(num / SECTOR_DEG);
        end
        return tab;
    endfunction

    localparam t_frac_tab FRAC_TAB = f_frac_tab();

    // floor(x / 65535) for x <= 65535^2: x = 65536a + b gives a + (a + b >= 65535).
    function automatic logic [IN_W-1:0] f_div_full(input logic [PROD_W-1:0] x);
        logic [IN_W:0] sum;
        sum = {1'b0, x[PROD_W-1:IN_W]} + {1'b0, x[IN_W-1:0]};
        return x[PROD_W-1:IN_W] + {{(IN_W-1){1'b0}}, (sum >= (IN_W+1)'(FULL_SCALE))};
    endfunction

    typedef struct packed {
        logic                 vld;
        t_sector              sector;
        logic [FRAC_BITS-1:0] frac;
        logic [IN_W-1:0]      sat;
        logic [IN_W-1:0]      bright;
        logic [IN_W-1:0]      p;
    } t_sec;

    typedef struct packed {
        logic            vld;
        logic [IN_W-1:0] red;
        logic [IN_W-1:0] green;
        logic [IN_W-1:0] blue;
    } t_rgb;

endpackage

### rtl/hsv2rgb_hue.sv
// Stages 1-3: hue mod 360, sector and sector fraction, p = V(1-S).
module hsv2rgb_hue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [hsv2rgb_pkg::IN_W-1:0]        i_hue_deg,
    input  logic [hsv2rgb_pkg::IN_W-1:0]        i_sat_frac,
    input  logic [hsv2rgb_pkg::IN_W-1:0]        i_bright_frac,
    input  logic                                i_take,
    output logic                                o_take,
    output hsv2rgb_pkg::t_sec                   o_sec
);

    localparam int SD = hsv2rgb_pkg::SECTOR_DEG;

    logic en1, en2, en3;

    // stage 1
    logic                                r_vld1;
    logic [hsv2rgb_pkg::IN_W-1:0]        r_hue1, r_sat1, r_bright1;
    logic [hsv2rgb_pkg::QE_W-1:0]        r_qe1, n_qe1;
    logic [hsv2rgb_pkg::PROD_W-1:0]      r_pprod1, n_pprod1;
    logic [hsv2rgb_pkg::PROD_W-1:0]      qe_prod;

    // stage 2
    logic                                r_vld2;
    logic [hsv2rgb_pkg::H_W-1:0]         r_h2, n_h2;
    logic [hsv2rgb_pkg::IN_W-1:0]        r_sat2, r_bright2, r_p2;
    logic [hsv2rgb_pkg::IN_W:0]          mul360, hdiff;
    logic [hsv2rgb_pkg::H_W:0]           h_raw;

    // stage 3
    logic                                r_vld3;
    hsv2rgb_pkg::t_sector                r_sector3, n_sector3;
    logic [hsv2rgb_pkg::FRAC_BITS-1:0]   r_frac3, n_frac3;
    logic [hsv2rgb_pkg::IN_W-1:0]        r_sat3, r_bright3, r_p3;
    logic [hsv2rgb_pkg::H_W-1:0]         base;
    logic [hsv2rgb_pkg::H_W-1:0]         hoff;
    logic [hsv2rgb_pkg::REM_W-1:0]       rem;

    assign en3    = !r_vld3 || i_take;
    assign en2    = !r_vld2 || en3;
    assign en1    = !r_vld1 || en2;
    assign o_take = en1;

    always_comb begin
        qe_prod  = hsv2rgb_pkg::PROD_W'(i_hue_deg)
                 * hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::RECIP_360);
        n_qe1    = hsv2rgb_pkg::QE_W'(qe_prod >> hsv2rgb_pkg::RECIP_SHIFT);
        n_pprod1 = hsv2rgb_pkg::PROD_W'(i_bright_frac)
                 * hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::IN_W'(hsv2rgb_pkg::FULL_SCALE) - i_sat_frac);
    end

    // reciprocal estimate leaves h in [0, 720): one conditional subtract
    always_comb begin
        mul360 = (hsv2rgb_pkg::IN_W+1)'(r_qe1) * (hsv2rgb_pkg::IN_W+1)'(hsv2rgb_pkg::HUE_CIRCLE);
        hdiff  = {1'b0, r_hue1} - mul360;
        h_raw  = hdiff[hsv2rgb_pkg::H_W:0];
        if (h_raw >= (hsv2rgb_pkg::H_W+1)'(hsv2rgb_pkg::HUE_CIRCLE)) begin
            n_h2 = hsv2rgb_pkg::H_W'(h_raw - (hsv2rgb_pkg::H_W+1)'(hsv2rgb_pkg::HUE_CIRCLE));
        end else begin
            n_h2 = hsv2rgb_pkg::H_W'(h_raw);
        end
    end

    always_comb begin
        case (r_h2) inside
            [0:SD-1]: begin
                n_sector3 = hsv2rgb_pkg::SEC_RED_YEL;
                base      = hsv2rgb_pkg::H_W'(0);
            end
            [SD:2*SD-1]: begin
                n_sector3 = hsv2rgb_pkg::SEC_YEL_GRN;
                base      = hsv2rgb_pkg::H_W'(SD);
            end
            [2*SD:3*SD-1]: begin
                n_sector3 = hsv2rgb_pkg::SEC_GRN_CYN;
                base      = hsv2rgb_pkg::H_W'(2*SD);
            end
            [3*SD:4*SD-1]: begin
                n_sector3 = hsv2rgb_pkg::SEC_CYN_BLU;
                base      = hsv2rgb_pkg::H_W'(3*SD);
            end
            [4*SD:5*SD-1]: begin
                n_sector3 = hsv2rgb_pkg::SEC_BLU_MAG;
                base      = hsv2rgb_pkg::H_W'(4*SD);
            end
            default: begin
                n_sector3 = hsv2rgb_pkg::SEC_MAG_RED;
                base      = hsv2rgb_pkg::H_W'(5*SD);
            end
        endcase
        hoff    = r_h2 - base;
        rem     = hoff[hsv2rgb_pkg::REM_W-1:0];
        n_frac3 = hsv2rgb_pkg::FRAC_TAB[rem];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (en1) r_vld1 <= i_valid;
            if (en2) r_vld2 <= r_vld1;
            if (en3) r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_hue1    <= i_hue_deg;
            r_sat1    <= i_sat_frac;
            r_bright1 <= i_bright_frac;
            r_qe1     <= n_qe1;
            r_pprod1  <= n_pprod1;
        end
        if (en2) begin
            r_h2      <= n_h2;
            r_sat2    <= r_sat1;
            r_bright2 <= r_bright1;
            r_p2      <= hsv2rgb_pkg::f_div_full(r_pprod1);
        end
        if (en3) begin
            r_sector3 <= n_sector3;
            r_frac3   <= n_frac3;
            r_sat3    <= r_sat2;
            r_bright3 <= r_bright2;
            r_p3      <= r_p2;
        end
    end

    assign o_sec.vld    = r_vld3;
    assign o_sec.sector = r_sector3;
    assign o_sec.frac   = r_frac3;
    assign o_sec.sat    = r_sat3;
    assign o_sec.bright = r_bright3;
    assign o_sec.p      = r_p3;

endmodule

### rtl/hsv2rgb_mix.sv
// Stages 4-6: sf/sg, q and t, and the six-way channel assignment.
module hsv2rgb_mix (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hsv2rgb_pkg::t_sec   i_sec,
    input  logic                i_take,
    output logic                o_take,
    output hsv2rgb_pkg::t_rgb   o_rgb
);

    localparam int W  = hsv2rgb_pkg::IN_W;
    localparam int FB = hsv2rgb_pkg::FRAC_BITS;

    logic en4, en5, en6;

    // stage 4
    logic                     r_vld4;
    hsv2rgb_pkg::t_sector     r_sector4;
    logic [W-1:0]             r_sf4, r_sg4, r_bright4, r_p4;
    logic [W+FB-1:0]          sf_prod;
    logic [W+FB:0]            sg_prod;
    logic [FB:0]              frac_c;

    // stage 5
    logic                     r_vld5;
    hsv2rgb_pkg::t_sector     r_sector5;
    logic [W-1:0]             r_bright5, r_p5;
    logic [hsv2rgb_pkg::PROD_W-1:0] r_qprod5, r_tprod5, n_qprod5, n_tprod5;

    // stage 6
    logic                     r_vld6;
    logic [W-1:0]             r_red6, r_green6, r_blue6;
    logic [W-1:0]             n_red6, n_green6, n_blue6;
    logic [W-1:0]             qv, tv;

    assign en6    = !r_vld6 || i_take;
    assign en5    = !r_vld5 || en6;
    assign en4    = !r_vld4 || en5;
    assign o_take = en4;

    always_comb begin
        frac_c  = (FB+1)'(1 << FB) - {1'b0, i_sec.frac};
        sf_prod = (W+FB)'(i_sec.sat) * (W+FB)'(i_sec.frac);
        sg_prod = (W+FB+1)'(i_sec.sat) * (W+FB+1)'(frac_c);
    end

    always_comb begin
        n_qprod5 = hsv2rgb_pkg::PROD_W'(r_bright4)
                 * hsv2rgb_pkg::PROD_W'(W'(hsv2rgb_pkg::FULL_SCALE) - r_sf4);
        n_tprod5 = hsv2rgb_pkg::PROD_W'(r_bright4)
                 * hsv2rgb_pkg::PROD_W'(W'(hsv2rgb_pkg::FULL_SCALE) - r_sg4);
    end

    always_comb begin
        qv = hsv2rgb_pkg::f_div_full(r_qprod5);
        tv = hsv2rgb_pkg::f_div_full(r_tprod5);
        case (r_sector5)
            hsv2rgb_pkg::SEC_RED_YEL: begin
                n_red6 = r_bright5; n_green6 = tv;        n_blue6 = r_p5;
            end
            hsv2rgb_pkg::SEC_YEL_GRN: begin
                n_red6 = qv;        n_green6 = r_bright5; n_blue6 = r_p5;
            end
            hsv2rgb_pkg::SEC_GRN_CYN: begin
                n_red6 = r_p5;      n_green6 = r_bright5; n_blue6 = tv;
            end
            hsv2rgb_pkg::SEC_CYN_BLU: begin
                n_red6 = r_p5;      n_green6 = qv;        n_blue6 = r_bright5;
            end
            hsv2rgb_pkg::SEC_BLU_MAG: begin
                n_red6 = tv;        n_green6 = r_p5;      n_blue6 = r_bright5;
            end
            default: begin
                n_red6 = r_bright5; n_green6 = r_p5;      n_blue6 = qv;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else begin
            if (en4) r_vld4 <= i_sec.vld;
            if (en5) r_vld5 <= r_vld4;
            if (en6) r_vld6 <= r_vld5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_sector4 <= i_sec.sector;
            r_sf4     <= sf_prod[FB +: W];
            r_sg4     <= sg_prod[FB +: W];
            r_bright4 <= i_sec.bright;
            r_p4      <= i_sec.p;
        end
        if (en5) begin
            r_sector5 <= r_sector4;
            r_bright5 <= r_bright4;
            r_p5      <= r_p4;
            r_qprod5  <= n_qprod5;
            r_tprod5  <= n_tprod5;
        end
        if (en6) begin
            r_red6   <= n_red6;
            r_green6 <= n_green6;
            r_blue6  <= n_blue6;
        end
    end

    assign o_rgb.vld   = r_vld6;
    assign o_rgb.red   = r_red6;
    assign o_rgb.green = r_green6;
    assign o_rgb.blue  = r_blue6;

endmodule

### rtl/hsv2rgb_scale.sv
// Stage 7: scale channels to 5/6/5 bits and hold the output register.
module hsv2rgb_scale (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  hsv2rgb_pkg::t_rgb                i_rgb,
    input  logic                             i_stall,
    output logic                             o_take,
    output logic                             o_valid,
    output logic [hsv2rgb_pkg::RB_W-1:0]     o_red_out,
    output logic [hsv2rgb_pkg::G_W-1:0]      o_green_out,
    output logic [hsv2rgb_pkg::RB_W-1:0]     o_blue_out
);

    localparam int PW = hsv2rgb_pkg::PROD_W;

    logic                            en7;
    logic                            r_vld7;
    logic [hsv2rgb_pkg::RB_W-1:0]    r_red7, r_blue7, n_red7, n_blue7;
    logic [hsv2rgb_pkg::G_W-1:0]     r_green7, n_green7;
    logic [hsv2rgb_pkg::IN_W-1:0]    red_q, green_q, blue_q;

    assign en7    = !r_vld7 || !i_stall;
    assign o_take = en7;

    // x * 31 and x * 63 are constant multiplies; then divide by full scale
    always_comb begin
        red_q    = hsv2rgb_pkg::f_div_full(PW'(i_rgb.red)   * PW'(hsv2rgb_pkg::RB_MAX));
        green_q  = hsv2rgb_pkg::f_div_full(PW'(i_rgb.green) * PW'(hsv2rgb_pkg::G_MAX));
        blue_q   = hsv2rgb_pkg::f_div_full(PW'(i_rgb.blue)  * PW'(hsv2rgb_pkg::RB_MAX));
        n_red7   = red_q[hsv2rgb_pkg::RB_W-1:0];
        n_green7 = green_q[hsv2rgb_pkg::G_W-1:0];
        n_blue7  = blue_q[hsv2rgb_pkg::RB_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld7 <= 1'b0;
        end else if (en7) begin
            r_vld7 <= i_rgb.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en7) begin
            r_red7   <= n_red7;
            r_green7 <= n_green7;
            r_blue7  <= n_blue7;
        end
    end

    assign o_valid     = r_vld7;
    assign o_red_out   = r_red7;
    assign o_green_out = r_green7;
    assign o_blue_out  = r_blue7;

endmodule

### rtl/hsv_to_rgb565_converter.sv
// HSV to RGB565 converter top level: seven-stage pipeline, one pixel per clock when unstalled.
//
// Converts one hue/saturation/brightness request into one RGB565 pixel.
// Hue is any 16-bit value in degrees and is reduced modulo 360; saturation
// and brightness are unsigned fractions with 0xFFFF as 1.0. An accepted
// request moves through the seven register stages in order, and o_valid is
// the valid bit of the last stage. A new request is taken every clock while
// the output is not stalled; the pipeline holds up to 7 requests, one per
// register stage. In order, the stages and their registers compute the
// hue reciprocal and V(1-S), mod-360 fixup and the p divide, sector and
// fraction lookup, S*F products, V(1-sS) products, q/t divide and channel
// select, and the final 5/6/5 scaling.
// Stall on the output moves back stage by stage: an empty stage keeps
// filling, so o_stall rises only when every stage holds a request and
// i_stall is high. All products truncate; results can be one LSB below a
// floating-point conversion.
`include "assert_macros.svh"

module hsv_to_rgb565_converter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [hsv2rgb_pkg::IN_W-1:0]     i_hue_deg,
    input  logic [hsv2rgb_pkg::IN_W-1:0]     i_sat_frac,
    input  logic [hsv2rgb_pkg::IN_W-1:0]     i_bright_frac,
    // pixel channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [hsv2rgb_pkg::RB_W-1:0]     o_red_out,
    output logic [hsv2rgb_pkg::G_W-1:0]      o_green_out,
    output logic [hsv2rgb_pkg::RB_W-1:0]     o_blue_out
);

    hsv2rgb_pkg::t_sec sec;
    hsv2rgb_pkg::t_rgb rgb;
    logic              take_hue;
    logic              take_mix;
    logic              take_scale;

    // Stages 1-3: hue reduction, sector/fraction, p.
    hsv2rgb_hue u_hue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_hue_deg     (i_hue_deg),
        .i_sat_frac    (i_sat_frac),
        .i_bright_frac (i_bright_frac),
        .i_take        (take_mix),
        .o_take        (take_hue),
        .o_sec         (sec)
    );

    // Stages 4-6: q, t and the sector-driven channel mapping.
    hsv2rgb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sec   (sec),
        .i_take  (take_scale),
        .o_take  (take_mix),
        .o_rgb   (rgb)
    );

    // Stage 7: channel scaling into the output register.
    hsv2rgb_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rgb       (rgb),
        .i_stall     (i_stall),
        .o_take      (take_scale),
        .o_valid     (o_valid),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

    assign o_stall = !take_hue;

    // Input stalls only with the whole pipeline full behind a stalled output.
    `HSV_ASSERT_IMPL(a_stall_full, o_stall, sec.vld && rgb.vld && o_valid && i_stall)
    // p = V(1-S) never exceeds brightness.
    `HSV_ASSERT_ALWAYS(a_p_le_v, !sec.vld || (sec.p <= sec.bright))
    // A blocked mid-pipe request is not dropped.
    `HSV_ASSERT_NEXT(a_sec_hold, sec.vld && !take_mix, sec.vld)

endmodule

### verif/tb.sv
// Self-checking testbench for the HSV to RGB565 converter.
module tb;
    import hsv2rgb_pkg::*;

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------
    // Slowest correct run: about 1725 requests, each with a drawn idle gap
    // on the source and a drawn stall on the pixel side, plus the 7-stage
    // pipeline. CYCLE_LIMIT leaves plenty of margin over that.
    localparam int CYCLE_LIMIT  = 400000;
    // Quiet cycles after the last pixel, long enough to catch a stray extra pixel.
    localparam int DRAIN_CYCLES = 32;
    // Mismatch lines printed before the report goes quiet (still counted).
    localparam int MAX_REPORTS  = 40;

    // How often a side idles: never, now and then, or with a random wait drawn for every item.
    typedef enum int {
        IDLE_NONE,
        IDLE_SOME,
        IDLE_HEAVY
    } idle_t;

    // One predicted RGB565 pixel.
    typedef struct {
        logic [RB_W-1:0] red;
        logic [G_W-1:0]  green;
        logic [RB_W-1:0] blue;
    } rgb565_t;

    // ------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------
    logic            i_clk         = 1'b0;
    logic            i_rst_n       = 1'b0;
    logic            i_valid       = 1'b0;
    logic            o_stall;
    logic [IN_W-1:0] i_hue_deg     = '0;
    logic [IN_W-1:0] i_sat_frac    = '0;
    logic [IN_W-1:0] i_bright_frac = '0;
    logic            o_valid;
    logic            i_stall       = 1'b0;
    logic [RB_W-1:0] o_red_out;
    logic [G_W-1:0]  o_green_out;
    logic [RB_W-1:0] o_blue_out;

    // Pixels predicted for accepted requests, oldest first.
    rgb565_t pending_pixels[$];

    idle_t   source_idle    = IDLE_NONE;
    idle_t   sink_idle      = IDLE_NONE;
    int      mismatch_count = 0;
    int      requests_sent  = 0;
    int      pixels_checked = 0;
    int      sector_hits[6] = '{default: 0};
    int      cycle_count    = 0;
    int      sink_wait;
    rgb565_t want_pixel;

    hsv_to_rgb565_converter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_hue_deg     (i_hue_deg),
        .i_sat_frac    (i_sat_frac),
        .i_bright_frac (i_bright_frac),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels still pending",
                     cycle_count, pending_pixels.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor: fixed-point HSV to RGB565, widths as in the block
    // ------------------------------------------------------------------
    function automatic rgb565_t predict_pixel(input logic [IN_W-1:0] hue,
                                              input logic [IN_W-1:0] sat,
                                              input logic [IN_W-1:0] bright);
        longint unsigned angle, sec_pos, frac, sat_f, sat_g;
        longint unsigned v, s, p, q, t, r, g, b;
        t_sector         sector;
        rgb565_t         px;
        v       = bright;
        s       = sat;
        angle   = hue % HUE_CIRCLE;
        sector  = t_sector'(angle / SECTOR_DEG);
        sec_pos = angle % SECTOR_DEG;
        // Position inside the sector, FRAC_BITS fraction bits.
        frac    = (sec_pos << FRAC_BITS) / SECTOR_DEG;
        sat_f   = (s * frac) >> FRAC_BITS;
        sat_g   = (s * ((64'd1 << FRAC_BITS) - frac)) >> FRAC_BITS;
        p       = v * (FULL_SCALE - s) / FULL_SCALE;
        q       = v * (FULL_SCALE - sat_f) / FULL_SCALE;
        t       = v * (FULL_SCALE - sat_g) / FULL_SCALE;
        case (sector)
            SEC_RED_YEL: begin r = v; g = t; b = p; end
            SEC_YEL_GRN: begin r = q; g = v; b = p; end
            SEC_GRN_CYN: begin r = p; g = v; b = t; end
            SEC_CYN_BLU: begin r = p; g = q; b = v; end
            SEC_BLU_MAG: begin r = t; g = p; b = v; end
            default:     begin r = v; g = p; b = q; end
        endcase
        px.red   = RB_W'(r * RB_MAX / FULL_SCALE);
        px.green = G_W'(g * G_MAX / FULL_SCALE);
        px.blue  = RB_W'(b * RB_MAX / FULL_SCALE);
        return px;
    endfunction

    function automatic int draw_wait(input idle_t mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
            default:   return $urandom_range(0, 15);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0d] mismatch: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Request side. Called in the time step of a rising edge; returns in
    // the time step of the edge that accepted the request, with i_valid
    // still high so back-to-back requests never drop valid.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [IN_W-1:0] hue,
                                input logic [IN_W-1:0] sat,
                                input logic [IN_W-1:0] bright);
        int gap;
        gap = draw_wait(source_idle);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_hue_deg     <= hue;
        i_sat_frac    <= sat;
        i_bright_frac <= bright;
        // Values read at the edge are the pre-edge ones, so this is the
        // exact acceptance condition the DUT sees.
        do @(posedge i_clk); while (o_stall);
        pending_pixels.push_back(predict_pixel(hue, sat, bright));
        sector_hits[(hue % HUE_CIRCLE) / SECTOR_DEG]++;
        requests_sent++;
    endtask

    // Saturation/brightness: mostly uniform, with a share at the edges.
    function automatic logic [IN_W-1:0] pick_fraction();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return IN_W'($urandom_range(0, 3));
            3:       return IN_W'(FULL_SCALE - $urandom_range(0, 3));
            default: return IN_W'($urandom);
        endcase
    endfunction

    task automatic send_random_request();
        logic [IN_W-1:0] hue;
        case ($urandom_range(0, 7))
            0, 1, 2: hue = IN_W'($urandom_range(0, HUE_CIRCLE - 1));
            // Sector edges, possibly several turns around the circle.
            3, 4:    hue = IN_W'($urandom_range(0, 5) * SECTOR_DEG
                                 + (($urandom_range(0, 1) == 0) ? 0 : SECTOR_DEG - 1)
                                 + $urandom_range(0, 20) * HUE_CIRCLE);
            default: hue = IN_W'($urandom);
        endcase
        send_request(hue, pick_fraction(), pick_fraction());
    endtask

    // ------------------------------------------------------------------
    // Pixel side: per pixel, stall for a drawn number of cycles, then
    // take the next pixel that shows up.
    // ------------------------------------------------------------------
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            sink_wait = draw_wait(sink_idle);
            if (sink_wait > 0) begin
                i_stall <= 1'b1;
                repeat (sink_wait) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Scoreboard: each accepted pixel against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel r=%0d g=%0d b=%0d with no request pending",
                                          o_red_out, o_green_out, o_blue_out));
            end else begin
                want_pixel = pending_pixels.pop_front();
                if (o_red_out !== want_pixel.red)
                    report_mismatch($sformatf("red got %0d want %0d",
                                              o_red_out, want_pixel.red));
                if (o_green_out !== want_pixel.green)
                    report_mismatch($sformatf("green got %0d want %0d",
                                              o_green_out, want_pixel.green));
                if (o_blue_out !== want_pixel.blue)
                    report_mismatch($sformatf("blue got %0d want %0d",
                                              o_blue_out, want_pixel.blue));
                pixels_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Full colour in the middle of each of the six sectors.
    task automatic test_sectors();
        for (int k = 0; k < 6; k++)
            send_request(IN_W'(k * SECTOR_DEG + SECTOR_DEG / 2), '1, '1);
    endtask

    // Hue reduction: 360 acts as 0, plus the top of the 16-bit range.
    task automatic test_hue_wrap();
        send_request(IN_W'(0), '1, '1);
        send_request(IN_W'(HUE_CIRCLE - 1), '1, '1);
        send_request(IN_W'(HUE_CIRCLE), '1, '1);
        send_request(IN_W'(HUE_CIRCLE + 1), '1, '1);
        send_request(IN_W'(2 * HUE_CIRCLE), '1, '1);
        send_request('1, '1, '1);
    endtask

    // Zero saturation gives grey.
    task automatic test_grey();
        send_request(IN_W'(45), '0, '1);
        send_request(IN_W'(200), '0, IN_W'(16'h8000));
        send_request('1, '0, IN_W'(1));
    endtask

    // Zero brightness gives black whatever the hue and saturation.
    task automatic test_black();
        send_request(IN_W'(100), '1, '0);
        send_request('1, '0, '0);
        send_request(IN_W'(330), IN_W'(16'h5A5A), '0);
    endtask

    // Remaining corners of the saturation/brightness range, plus one mid-range pattern.
    task automatic test_field_extremes();
        send_request('0, '0, '0);
        send_request(IN_W'(59), IN_W'(1), IN_W'(FULL_SCALE - 1));
        send_request(IN_W'(299), IN_W'(FULL_SCALE - 1), IN_W'(1));
        send_request(IN_W'(16'hAAAA), IN_W'(16'h5555), IN_W'(16'hAAAA));
    endtask

    // One request per clock with the pixel side always ready.
    task automatic test_full_rate();
        source_idle = IDLE_NONE;
        sink_idle   = IDLE_NONE;
        repeat (400) send_random_request();
    endtask

    // Source keeps the pipe full while the pixel side stalls a lot, so
    // o_stall has to push back.
    task automatic test_sink_backpressure();
        source_idle = IDLE_NONE;
        sink_idle   = IDLE_HEAVY;
        repeat (400) send_random_request();
    endtask

    // Sparse requests into a ready pixel side: the pipeline can drain between them.
    task automatic test_source_gaps();
        source_idle = IDLE_HEAVY;
        sink_idle   = IDLE_NONE;
        repeat (300) send_random_request();
    endtask

    // Both sides idle at random, with some stretches of full rate.
    task automatic test_mixed_idling();
        for (int burst = 0; burst < 6; burst++) begin
            source_idle = (burst % 3 == 0) ? IDLE_NONE : IDLE_SOME;
            sink_idle   = (burst % 2 == 0) ? IDLE_SOME : IDLE_HEAVY;
            repeat (100) send_random_request();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_sectors();
        test_hue_wrap();
        test_grey();
        test_black();
        test_field_extremes();
        test_full_rate();
        test_sink_backpressure();
        test_source_gaps();
        test_mixed_idling();

        // Last request was accepted at this edge; drop valid now.
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d colour requests, compared %0d pixels in %0d cycles.",
                 requests_sent, pixels_checked, cycle_count);
        $display("Per-sector counts %0d/%0d/%0d/%0d/%0d/%0d, mismatches %0d.",
                 sector_hits[0], sector_hits[1], sector_hits[2],
                 sector_hits[3], sector_hits[4], sector_hits[5], mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
